>>> hdl/ntc_pkg.sv
// ----------------------------------------------------------------------------
// NTC converter package
// Shared widths, register indexes, fault codes, constants and the sideband
// word that travels beside the arithmetic through every pipeline stage.
// ----------------------------------------------------------------------------
package ntc_pkg;

    // Register file.
    localparam int unsigned RES_W     = 20;
    localparam int unsigned BETA_W    = 14;
    localparam int unsigned CFG_W     = 20;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BETA    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOMINAL = 2'd2;

    localparam logic [RES_W-1:0]  DIVIDER_RESET = 20'd10000;
    localparam logic [BETA_W-1:0] BETA_RESET    = 14'd3950;
    localparam logic [RES_W-1:0]  NOMINAL_RESET = 20'd10000;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_OPEN  = 2'd1;
    localparam logic [1:0] FAULT_SHORT = 2'd2;
    localparam logic [1:0] FAULT_RANGE = 2'd3;

    // Logarithm: 5 bit integer part and 24 fraction bits, one stage to
    // normalise and one squaring stage per fraction bit.
    localparam int unsigned LOG_FRAC_BITS = 24;
    localparam int unsigned LOG_EXP_BITS  = 5;
    localparam int unsigned LOG_W         = LOG_EXP_BITS + LOG_FRAC_BITS;
    localparam int unsigned LOG_STAGES    = LOG_FRAC_BITS + 1;
    localparam int unsigned MANT_W        = 31;
    localparam int unsigned SQ_W          = 2 * MANT_W;

    // Denominator arithmetic.
    localparam int unsigned L_SUM_W = LOG_W + 2;
    localparam int unsigned L_MAG_W = LOG_W + 1;
    localparam int unsigned K_W     = 32;
    localparam int unsigned PROD_W  = L_MAG_W + K_W;
    localparam int unsigned PM_W    = PROD_W - 16;
    localparam int unsigned D_S_W   = 48;
    localparam int unsigned D_W     = D_S_W - 1;
    localparam int unsigned NB_W    = 29;
    localparam int unsigned NUM_W   = NB_W + 32;

    // Divider: 17 quotient bits after an overflow check.
    localparam int unsigned Q_BITS  = 17;
    localparam int unsigned DSH_W   = D_W + Q_BITS;
    localparam int unsigned C_W     = Q_BITS + 2;

    // T0 * ln2 in Q24, and T0 in centikelvin.
    localparam logic [K_W-1:0] K_T0_LN2 =
        K_W'(64'd29815 * 64'd2977044472 / 64'd25600);
    localparam logic [14:0] T0_CENTI     = 15'd29815;
    localparam int          ZERO_C_CENTI = 27315;

    localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;
    localparam logic signed [15:0] TEMP_MIN = 16'sh8000;

    // Sideband word: a fault found early wins over everything computed later.
    typedef struct packed {
        logic              valid;
        logic [1:0]        fault;
        logic              sat_low;
        logic [BETA_W-1:0] beta;
    } ntc_side_t;

endpackage

>>> hdl/ntc_log2_pipe.sv
// ----------------------------------------------------------------------------
// Pipelined base-two logarithm
// Normalises a positive integer in one stage, then produces one fraction bit
// per stage by squaring the mantissa, giving log2 in Q24.
// ----------------------------------------------------------------------------
module ntc_log2_pipe #(
    parameter int IN_W = 20
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [IN_W-1:0]             x,
    output logic [ntc_pkg::LOG_W-1:0]   y
);

    localparam int STAGES = ntc_pkg::LOG_STAGES;

    logic [ntc_pkg::MANT_W-1:0]        m_reg  [STAGES];
    logic [ntc_pkg::MANT_W-1:0]        m_next [STAGES];
    logic [ntc_pkg::LOG_EXP_BITS-1:0]  e_reg  [STAGES];
    logic [ntc_pkg::LOG_EXP_BITS-1:0]  e_next [STAGES];
    logic [ntc_pkg::LOG_FRAC_BITS-1:0] f_reg  [STAGES];
    logic [ntc_pkg::LOG_FRAC_BITS-1:0] f_next [STAGES];

    always_comb
    begin
        logic [ntc_pkg::SQ_W-1:0] sq;
        logic [31:0]              t;
        sq = '0;
        t  = '0;
        // The integer part is the position of the leading one.
        e_next[0] = '0;
        for (int i = 0; i < IN_W; i++)
        begin
            if (x[i])
            begin
                e_next[0] = ntc_pkg::LOG_EXP_BITS'(i);
            end
        end
        m_next[0] = ntc_pkg::MANT_W'(x) << (5'd30 - e_next[0]);
        f_next[0] = '0;
        // Each squaring doubles the logarithm; a carry into bit 31 is a one.
        for (int j = 1; j < STAGES; j++)
        begin
            sq        = ntc_pkg::SQ_W'(m_reg[j-1]) * ntc_pkg::SQ_W'(m_reg[j-1]);
            t         = sq[61:30];
            e_next[j] = e_reg[j-1];
            f_next[j] = f_reg[j-1];
            if (t[31])
            begin
                m_next[j] = t[31:1];
                f_next[j][ntc_pkg::LOG_FRAC_BITS-j] = 1'b1;
            end
            else
            begin
                m_next[j] = t[30:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < STAGES; j++)
            begin
                m_reg[j] <= m_next[j];
                e_reg[j] <= e_next[j];
                f_reg[j] <= f_next[j];
            end
        end
    end

    assign y = {e_reg[STAGES-1], f_reg[STAGES-1]};

endmodule

>>> hdl/ntc_denom.sv
// ----------------------------------------------------------------------------
// Beta equation denominator
// Sums the four logarithms, scales by T0*ln2 and adds beta to form the
// denominator in Q32 over three stages; also forms the numerator scale.
// ----------------------------------------------------------------------------
module ntc_denom (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic [ntc_pkg::LOG_W-1:0]   log_r1,
    input  logic [ntc_pkg::LOG_W-1:0]   log_hi,
    input  logic [ntc_pkg::LOG_W-1:0]   log_lo,
    input  logic [ntc_pkg::LOG_W-1:0]   log_r0,
    input  ntc_pkg::ntc_side_t          side_in,
    output logic [ntc_pkg::D_W-1:0]     d_out,
    output logic [ntc_pkg::NB_W-1:0]    nb_out,
    output ntc_pkg::ntc_side_t          side_out
);

    logic                               l_neg_reg, l_neg_next;
    logic [ntc_pkg::L_MAG_W-1:0]        l_mag_reg, l_mag_next;
    logic                               l_neg2_reg;
    logic [ntc_pkg::PROD_W-1:0]         prod_reg, prod_next;
    logic [ntc_pkg::NB_W-1:0]           nb2_reg, nb2_next, nb3_reg;
    logic [ntc_pkg::D_W-1:0]            d_reg, d_next;
    ntc_pkg::ntc_side_t                 side1_reg, side2_reg, side3_reg, side3_next;
    logic signed [ntc_pkg::L_SUM_W-1:0] l_sum;
    logic [ntc_pkg::PM_W-1:0]           pm;
    logic signed [ntc_pkg::D_S_W-1:0]   base, d_s;

    always_comb
    begin
        l_sum = $signed({2'b00, log_r1}) + $signed({2'b00, log_hi})
              - $signed({2'b00, log_lo}) - $signed({2'b00, log_r0});
        l_neg_next = l_sum[ntc_pkg::L_SUM_W-1];
        l_mag_next = l_neg_next ? ntc_pkg::L_MAG_W'(-l_sum)
                                : l_sum[ntc_pkg::L_MAG_W-1:0];

        prod_next = ntc_pkg::PROD_W'(l_mag_reg) * ntc_pkg::PROD_W'(ntc_pkg::K_T0_LN2);
        nb2_next  = ntc_pkg::NB_W'(ntc_pkg::NB_W'(side1_reg.beta)
                                   * ntc_pkg::NB_W'(ntc_pkg::T0_CENTI));

        // Magnitude shifted down, then signed: truncation toward zero.
        pm   = prod_reg[ntc_pkg::PROD_W-1:16];
        base = $signed({2'b00, side2_reg.beta, 32'b0});
        d_s  = l_neg2_reg ? base - $signed({2'b00, pm}) : base + $signed({2'b00, pm});
        d_next     = d_s[ntc_pkg::D_W-1:0];
        side3_next = side2_reg;
        if (side2_reg.fault == ntc_pkg::FAULT_NONE
            && (d_s[ntc_pkg::D_S_W-1] || d_s == '0))
        begin
            side3_next.fault   = ntc_pkg::FAULT_RANGE;
            side3_next.sat_low = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side1_reg <= '0;
            side2_reg <= '0;
            side3_reg <= '0;
        end
        else if (en)
        begin
            side1_reg <= side_in;
            side2_reg <= side1_reg;
            side3_reg <= side3_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_neg_reg  <= l_neg_next;
            l_mag_reg  <= l_mag_next;
            l_neg2_reg <= l_neg_reg;
            prod_reg   <= prod_next;
            nb2_reg    <= nb2_next;
            nb3_reg    <= nb2_reg;
            d_reg      <= d_next;
        end
    end

    assign d_out    = d_reg;
    assign nb_out   = nb3_reg;
    assign side_out = side3_reg;

endmodule

>>> hdl/ntc_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Checks that the quotient fits 17 bits, then resolves one quotient bit per
// stage by compare and subtract of the shifted denominator.
// ----------------------------------------------------------------------------
module ntc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic [ntc_pkg::D_W-1:0]      d_in,
    input  logic [ntc_pkg::NB_W-1:0]     nb_in,
    input  ntc_pkg::ntc_side_t           side_in,
    output logic [ntc_pkg::Q_BITS-1:0]   q_out,
    output logic                         rem_nz,
    output ntc_pkg::ntc_side_t           side_out
);

    localparam int STAGES = ntc_pkg::Q_BITS + 1;

    logic [ntc_pkg::NUM_W-1:0]  rem_reg  [STAGES];
    logic [ntc_pkg::NUM_W-1:0]  rem_next [STAGES];
    logic [ntc_pkg::D_W-1:0]    d_reg    [STAGES];
    logic [ntc_pkg::D_W-1:0]    d_next   [STAGES];
    logic [ntc_pkg::Q_BITS-1:0] q_reg    [STAGES];
    logic [ntc_pkg::Q_BITS-1:0] q_next   [STAGES];
    ntc_pkg::ntc_side_t         side_reg  [STAGES];
    ntc_pkg::ntc_side_t         side_next [STAGES];

    always_comb
    begin
        logic [ntc_pkg::NUM_W-1:0] num;
        logic [ntc_pkg::DSH_W-1:0] dsh;
        logic [ntc_pkg::DSH_W-1:0] rem_x;
        num   = {nb_in, 32'b0};
        dsh   = '0;
        rem_x = '0;
        rem_next[0]  = num;
        d_next[0]    = d_in;
        q_next[0]    = '0;
        side_next[0] = side_in;
        // A quotient of 2^17 or more is far above the output range.
        if (side_in.fault == ntc_pkg::FAULT_NONE
            && ntc_pkg::DSH_W'(num) >= {d_in, {ntc_pkg::Q_BITS{1'b0}}})
        begin
            side_next[0].fault   = ntc_pkg::FAULT_RANGE;
            side_next[0].sat_low = 1'b0;
        end
        for (int k = 1; k < STAGES; k++)
        begin
            dsh          = ntc_pkg::DSH_W'(d_reg[k-1]) << (ntc_pkg::Q_BITS - k);
            rem_x        = ntc_pkg::DSH_W'(rem_reg[k-1]);
            d_next[k]    = d_reg[k-1];
            side_next[k] = side_reg[k-1];
            q_next[k]    = q_reg[k-1];
            rem_next[k]  = rem_reg[k-1];
            if (rem_x >= dsh)
            begin
                rem_next[k] = ntc_pkg::NUM_W'(rem_x - dsh);
                q_next[k][ntc_pkg::Q_BITS-k] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                side_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                side_reg[k] <= side_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STAGES; k++)
            begin
                rem_reg[k] <= rem_next[k];
                d_reg[k]   <= d_next[k];
                q_reg[k]   <= q_next[k];
            end
        end
    end

    assign q_out    = q_reg[STAGES-1];
    assign rem_nz   = (rem_reg[STAGES-1] != '0);
    assign side_out = side_reg[STAGES-1];

endmodule

>>> hdl/ntc_beta_temperature_converter.sv
// ----------------------------------------------------------------------------
// NTC thermistor temperature converter
// Turns a divider converter code into hundredths of a degree Celsius through
// the beta equation, fully pipelined in fixed point.
// ----------------------------------------------------------------------------
// Usage. Converter codes arrive on the input channel (in_valid, in_stall,
// adc_code); each word yields exactly one result word on the output channel
// (out_valid, out_stall, temp_centi_c, fault_code), in order.
// Throughput is one word per clock cycle while the receiver does not stall.
// A word passes 47 register stages: 25 of logarithm (one normalising stage
// and one squaring multiplier per fraction bit), 3 to form the denominator,
// 18 of divider (one overflow check and one quotient bit per stage) and the
// output register. The first stage loads at the accepting edge, and out_valid
// rises with the edge that loads the word into the output register.
// The whole pipeline advances on one enable. While the output register holds
// a word that the receiver stalls, every stage holds and in_stall is raised,
// so nothing is lost or repeated; otherwise in_stall is low.
// Reset empties the pipeline and loads the default register values (10 kohm
// divider, beta 3950, 10 kohm nominal). The registers are written through
// cfg_wr_en, cfg_index and cfg_data, and should only change while no word is
// in flight. Faults: open input, shorted input, and out of range (including
// a zero resistor setting or a non-positive denominator) saturate the output.
// ----------------------------------------------------------------------------
module ntc_beta_temperature_converter #(
    parameter int ADC_BITS = 13
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ntc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ntc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [ADC_BITS-1:0]              adc_code,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic signed [15:0]               temp_centi_c,
    output logic [1:0]                       fault_code
);

    localparam logic [ADC_BITS-1:0] FULL_SCALE = '1;
    localparam int                  DLY        = ntc_pkg::LOG_STAGES;

    logic [ntc_pkg::RES_W-1:0]  div_res_reg;
    logic [ntc_pkg::BETA_W-1:0] beta_reg;
    logic [ntc_pkg::RES_W-1:0]  nom_res_reg;

    logic                       en;
    ntc_pkg::ntc_side_t         side_in;
    ntc_pkg::ntc_side_t         side_dly_reg [DLY];
    logic [ADC_BITS-1:0]        code_hi;
    logic [ntc_pkg::LOG_W-1:0]  log_r1, log_hi, log_lo, log_r0;
    logic [ntc_pkg::D_W-1:0]    d_val;
    logic [ntc_pkg::NB_W-1:0]   nb_val;
    ntc_pkg::ntc_side_t         den_side, div_side;
    logic [ntc_pkg::Q_BITS-1:0] div_q;
    logic                       div_rem_nz;

    logic                       out_valid_reg;
    logic signed [15:0]         temp_reg, temp_next;
    logic [1:0]                 fault_reg, fault_next;
    logic signed [ntc_pkg::C_W-1:0] c_s;

    // The pipeline moves unless a finished word waits on a stalled receiver.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    // Register file.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_res_reg <= ntc_pkg::DIVIDER_RESET;
            beta_reg    <= ntc_pkg::BETA_RESET;
            nom_res_reg <= ntc_pkg::NOMINAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ntc_pkg::REG_DIVIDER: div_res_reg <= cfg_data;
                ntc_pkg::REG_BETA:    beta_reg    <= cfg_data[ntc_pkg::BETA_W-1:0];
                ntc_pkg::REG_NOMINAL: nom_res_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Faults that are known on entry travel beside the logarithm pipes.
    always_comb
    begin
        side_in.valid   = in_valid;
        side_in.beta    = beta_reg;
        side_in.fault   = ntc_pkg::FAULT_NONE;
        side_in.sat_low = 1'b0;
        priority if (adc_code == '0)
        begin
            side_in.fault   = ntc_pkg::FAULT_OPEN;
            side_in.sat_low = 1'b1;
        end
        else if (adc_code == FULL_SCALE)
        begin
            side_in.fault = ntc_pkg::FAULT_SHORT;
        end
        else if (div_res_reg == '0)
        begin
            side_in.fault = ntc_pkg::FAULT_RANGE;
        end
        else if (nom_res_reg == '0)
        begin
            side_in.fault   = ntc_pkg::FAULT_RANGE;
            side_in.sat_low = 1'b1;
        end
        else
        begin
            side_in.fault = ntc_pkg::FAULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DLY; i++)
            begin
                side_dly_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_dly_reg[0] <= side_in;
            for (int i = 1; i < DLY; i++)
            begin
                side_dly_reg[i] <= side_dly_reg[i-1];
            end
        end
    end

    // Four logarithm lanes: R1, FS - code, code and R0.
    assign code_hi = FULL_SCALE - adc_code;

    ntc_log2_pipe #(.IN_W(ntc_pkg::RES_W)) u_log_r1 (
        .clk (clk), .en (en), .x (div_res_reg), .y (log_r1)
    );
    ntc_log2_pipe #(.IN_W(ADC_BITS)) u_log_hi (
        .clk (clk), .en (en), .x (code_hi), .y (log_hi)
    );
    ntc_log2_pipe #(.IN_W(ADC_BITS)) u_log_lo (
        .clk (clk), .en (en), .x (adc_code), .y (log_lo)
    );
    ntc_log2_pipe #(.IN_W(ntc_pkg::RES_W)) u_log_r0 (
        .clk (clk), .en (en), .x (nom_res_reg), .y (log_r0)
    );

    ntc_denom u_denom (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .log_r1   (log_r1),
        .log_hi   (log_hi),
        .log_lo   (log_lo),
        .log_r0   (log_r0),
        .side_in  (side_dly_reg[DLY-1]),
        .d_out    (d_val),
        .nb_out   (nb_val),
        .side_out (den_side)
    );

    ntc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .d_in     (d_val),
        .nb_in    (nb_val),
        .side_in  (den_side),
        .q_out    (div_q),
        .rem_nz   (div_rem_nz),
        .side_out (div_side)
    );

    // Offset to Celsius, truncate toward zero and saturate. The quotient is
    // never negative, so only the upper bound can be crossed here.
    always_comb
    begin
        c_s = $signed({2'b00, div_q}) - ntc_pkg::C_W'(ntc_pkg::ZERO_C_CENTI);
        if (c_s[ntc_pkg::C_W-1] && div_rem_nz)
        begin
            c_s = c_s + ntc_pkg::C_W'(1);
        end
        if (div_side.fault != ntc_pkg::FAULT_NONE)
        begin
            temp_next  = div_side.sat_low ? ntc_pkg::TEMP_MIN : ntc_pkg::TEMP_MAX;
            fault_next = div_side.fault;
        end
        else if (c_s > $signed(ntc_pkg::C_W'(32767)))
        begin
            temp_next  = ntc_pkg::TEMP_MAX;
            fault_next = ntc_pkg::FAULT_RANGE;
        end
        else
        begin
            temp_next  = c_s[15:0];
            fault_next = ntc_pkg::FAULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= div_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            temp_reg  <= temp_next;
            fault_reg <= fault_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign temp_centi_c = temp_reg;
    assign fault_code   = fault_reg;

    // An open input always reads as the lowest temperature.
    a_open_low : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_code == ntc_pkg::FAULT_OPEN |-> temp_centi_c == ntc_pkg::TEMP_MIN)
        else $error("open input word without low saturation");

    // A shorted input always reads as the highest temperature.
    a_short_high : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_code == ntc_pkg::FAULT_SHORT |-> temp_centi_c == ntc_pkg::TEMP_MAX)
        else $error("short input word without high saturation");

    // A good result never lies below absolute zero.
    a_above_zero_k : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fault_code == ntc_pkg::FAULT_NONE |-> temp_centi_c >= -16'sd27315)
        else $error("good word below absolute zero");

endmodule
